@@ hdl/rle8_pkg.sv @@
// Shared types and constants for the 8-bit run-length bitmap decoder.
// No dependencies; every other file of the block imports this package.
package rle8_pkg;

    localparam int unsigned MAX_DIM_DEF = 4096;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIM_W   = 13;  // configuration width / height
    localparam int unsigned COL_W   = 13;  // running column
    localparam int unsigned ROW_W   = 14;  // running row, signed
    localparam int unsigned OUT_W   = 12;  // reported row / column
    localparam int unsigned CIDX_W  = 2;

    localparam int unsigned DIM_SAT = 8191;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BOTTOM_UP    = 2'd2;

    // Second byte of an escape pair
    localparam logic [BYTE_W-1:0] ESC_END_LINE   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_END_BITMAP = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA      = 8'd2;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_LITERAL = 3'd3,
        PH_PAD     = 3'd4,
        PH_DX      = 3'd5,
        PH_DY      = 3'd6
    } t_phase;

    typedef struct packed {
        logic [OUT_W-1:0]  row_index;
        logic [OUT_W-1:0]  column_start;
        logic [BYTE_W-1:0] run_length;
        logic [BYTE_W-1:0] pixel_value;
        logic              out_of_bounds;
        logic              bitmap_done;
    } t_run;

    typedef struct packed {
        logic              valid;
        logic [CIDX_W-1:0] index;
        logic [DIM_W-1:0]  data;
    } t_cfg_wr;

endpackage

@@ hdl/rle8_if.sv @@
// Channel interfaces: compressed byte stream, run results and register writes.
// Depends on rle8_pkg for field widths.
interface rle8_byte_if;
    import rle8_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rle8_run_if;
    import rle8_pkg::*;
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  row_index;
    logic [OUT_W-1:0]  column_start;
    logic [BYTE_W-1:0] run_length;
    logic [BYTE_W-1:0] pixel_value;
    logic              out_of_bounds;
    logic              bitmap_done;
    modport source (output valid, output row_index, output column_start, output run_length,
                    output pixel_value, output out_of_bounds, output bitmap_done, input ready);
    modport sink   (input valid, input row_index, input column_start, input run_length,
                    input pixel_value, input out_of_bounds, input bitmap_done, output ready);
endinterface

interface rle8_cfg_if;
    import rle8_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [DIM_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/rle8_parser.sv @@
// Byte parser: phase machine, position tracking, settings and run formation.
// Depends on rle8_pkg.
module rle8_parser #(
    parameter int unsigned MAX_DIM = rle8_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rle8_pkg::t_cfg_wr           i_cfg,
    input  logic                        i_accept,
    input  logic [rle8_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_res_valid,
    output rle8_pkg::t_run              o_res
);
    import rle8_pkg::*;

    localparam int unsigned DimCap = (MAX_DIM > DIM_SAT) ? DIM_SAT : MAX_DIM;
    localparam logic signed [ROW_W:0] RowHi = (ROW_W+1)'(8191);
    localparam logic signed [ROW_W:0] RowLo = -(ROW_W+1)'(8192);
    localparam logic [COL_W:0]        ColHi = (COL_W+1)'(8191);
    localparam logic [DIM_W-1:0]      OutMax = DIM_W'((1 << OUT_W) - 1);

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > DimCap) begin
            r = DIM_W'(DimCap);
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_phase                   r_phase, n_phase;
    logic [BYTE_W-1:0]        r_held, n_held;
    logic [BYTE_W-1:0]        r_lit_left, n_lit_left;
    logic                     r_pad, n_pad;
    logic [BYTE_W-1:0]        r_dx, n_dx;
    logic [COL_W-1:0]         r_col, n_col;
    logic signed [ROW_W-1:0]  r_row, n_row;
    logic [DIM_W-1:0]         r_width, n_width;
    logic [DIM_W-1:0]         r_height, n_height;
    logic                     r_bottom_up, n_bottom_up;

    logic                     cfg_hit;
    logic [DIM_W-1:0]         eff_w, eff_h;
    logic signed [ROW_W-1:0]  start_row;
    logic [BYTE_W-1:0]        lit_dec;
    logic [BYTE_W-1:0]        run_len;
    logic [BYTE_W-1:0]        col_step;
    logic [COL_W:0]           col_sum;
    logic [COL_W-1:0]         col_sat;
    logic [BYTE_W-1:0]        row_step;
    logic signed [ROW_W:0]    row_sum;
    logic signed [ROW_W-1:0]  row_sat;
    logic                     row_neg, row_high;
    logic [DIM_W-1:0]         row_clamp;
    logic                     is_done;

    // Only a write to a known register re-arms the parser
    assign cfg_hit = i_cfg.valid && (i_cfg.index == CFG_IMAGE_WIDTH ||
                                     i_cfg.index == CFG_IMAGE_HEIGHT ||
                                     i_cfg.index == CFG_BOTTOM_UP);

    // Settings as they stand after this cycle's write, for the re-arm position
    always_comb begin
        n_width     = r_width;
        n_height    = r_height;
        n_bottom_up = r_bottom_up;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:  n_width     = i_cfg.data;
                CFG_IMAGE_HEIGHT: n_height    = i_cfg.data;
                CFG_BOTTOM_UP:    n_bottom_up = i_cfg.data[0];
                default:          n_width     = r_width;
            endcase
        end
    end

    assign eff_w     = eff_dim(r_width);
    assign eff_h     = eff_dim(r_height);
    assign start_row = n_bottom_up ? ROW_W'(eff_dim(n_height)) - ROW_W'(1) : '0;

    assign lit_dec  = (r_lit_left == '0) ? '0 : r_lit_left - BYTE_W'(1);
    assign run_len  = (r_phase == PH_VALUE) ? r_held : BYTE_W'(1);
    assign col_step = (r_phase == PH_DY) ? r_dx : run_len;
    assign col_sum  = {1'b0, r_col} + (COL_W+1)'(col_step);
    assign col_sat  = (col_sum > ColHi) ? COL_W'(8191) : col_sum[COL_W-1:0];

    assign row_step = (r_phase == PH_DY) ? i_byte : BYTE_W'(1);
    assign row_sum  = r_bottom_up ? (ROW_W+1)'(r_row) - $signed({1'b0, row_step})
                                  : (ROW_W+1)'(r_row) + $signed({1'b0, row_step});
    always_comb begin
        if (row_sum > RowHi) begin
            row_sat = RowHi[ROW_W-1:0];
        end else if (row_sum < RowLo) begin
            row_sat = RowLo[ROW_W-1:0];
        end else begin
            row_sat = row_sum[ROW_W-1:0];
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (cfg_hit) begin
            n_phase = PH_FIRST;
        end else if (i_accept) begin
            case (r_phase)
                PH_FIRST:   n_phase = (i_byte != '0) ? PH_VALUE : PH_ESCAPE;
                PH_VALUE:   n_phase = PH_FIRST;
                PH_ESCAPE: begin
                    if (i_byte == ESC_END_LINE || i_byte == ESC_END_BITMAP) begin
                        n_phase = PH_FIRST;
                    end else if (i_byte == ESC_DELTA) begin
                        n_phase = PH_DX;
                    end else begin
                        n_phase = PH_LITERAL;
                    end
                end
                PH_LITERAL: begin
                    if (lit_dec == '0) begin
                        n_phase = r_pad ? PH_PAD : PH_FIRST;
                    end
                end
                PH_PAD:     n_phase = PH_FIRST;
                PH_DX:      n_phase = PH_DY;
                PH_DY:      n_phase = PH_FIRST;
                default:    n_phase = PH_FIRST;
            endcase
        end
    end

    // Counters and position
    always_comb begin
        n_held     = r_held;
        n_lit_left = r_lit_left;
        n_pad      = r_pad;
        n_dx       = r_dx;
        n_col      = r_col;
        n_row      = r_row;
        if (cfg_hit || (i_accept && is_done)) begin
            n_held     = '0;
            n_lit_left = '0;
            n_pad      = 1'b0;
            n_dx       = '0;
            n_col      = '0;
            n_row      = start_row;
        end else if (i_accept) begin
            case (r_phase)
                PH_FIRST:   n_held = i_byte;
                PH_VALUE:   n_col  = col_sat;
                PH_ESCAPE: begin
                    if (i_byte == ESC_END_LINE) begin
                        n_col = '0;
                        n_row = row_sat;
                    end else if (i_byte != ESC_DELTA) begin
                        n_held     = i_byte;
                        n_lit_left = i_byte;
                        n_pad      = i_byte[0];
                    end
                end
                PH_LITERAL: begin
                    n_lit_left = lit_dec;
                    n_col      = col_sat;
                end
                PH_PAD:     n_pad = 1'b0;
                PH_DX:      n_dx  = i_byte;
                PH_DY: begin
                    n_col = col_sat;
                    n_row = row_sat;
                end
                default:    n_held = r_held;
            endcase
        end
    end

    // Result formation
    assign is_done   = (r_phase == PH_ESCAPE) && (i_byte == ESC_END_BITMAP);
    assign row_neg   = r_row[ROW_W-1];
    assign row_high  = !row_neg && (r_row[ROW_W-2:0] >= (ROW_W-1)'(eff_h));
    assign row_clamp = row_neg ? '0 : (row_high ? eff_h - DIM_W'(1) : r_row[DIM_W-1:0]);

    always_comb begin
        o_res_valid = i_accept && !cfg_hit &&
                      (r_phase == PH_VALUE || r_phase == PH_LITERAL || is_done);
        if (is_done) begin
            o_res             = '0;
            o_res.bitmap_done = 1'b1;
        end else begin
            o_res.row_index     = (row_clamp > OutMax) ? '1 : row_clamp[OUT_W-1:0];
            o_res.column_start  = (r_col > COL_W'(OutMax)) ? '1 : r_col[OUT_W-1:0];
            o_res.run_length    = run_len;
            o_res.pixel_value   = i_byte;
            o_res.out_of_bounds = row_neg || row_high || (col_sum > (COL_W+1)'(eff_w));
            o_res.bitmap_done   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_held      <= '0;
            r_lit_left  <= '0;
            r_pad       <= 1'b0;
            r_dx        <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_width     <= DIM_W'(1);
            r_height    <= DIM_W'(1);
            r_bottom_up <= 1'b1;
        end else begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_lit_left  <= n_lit_left;
            r_pad       <= n_pad;
            r_dx        <= n_dx;
            r_col       <= n_col;
            r_row       <= n_row;
            r_width     <= n_width;
            r_height    <= n_height;
            r_bottom_up <= n_bottom_up;
        end
    end

endmodule

@@ hdl/rle8_out_buf.sv @@
// Two-entry result buffer between the parser and the run channel.
// Depends on rle8_pkg for the run record.
module rle8_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rle8_pkg::t_run i_data,
    output logic           o_space,
    output logic           o_valid,
    output rle8_pkg::t_run o_data,
    input  logic           i_ready
);
    import rle8_pkg::*;

    logic [1:0] r_valid;
    t_run       r_slot [2];
    logic       pop;

    assign pop     = r_valid[0] && i_ready;
    assign o_space = !r_valid[1];
    assign o_valid = r_valid[0];
    assign o_data  = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            case ({pop, i_push})
                2'b11: r_valid <= r_valid;
                2'b10: r_valid <= {1'b0, r_valid[1]};
                2'b01: r_valid <= r_valid[0] ? 2'b11 : 2'b01;
                default: r_valid <= r_valid;
            endcase
        end
    end

    // Head of queue stays in slot 0
    always_ff @(posedge i_clk) begin
        case ({pop, i_push})
            2'b11: begin
                if (r_valid[1]) begin
                    r_slot[0] <= r_slot[1];
                    r_slot[1] <= i_data;
                end else begin
                    r_slot[0] <= i_data;
                end
            end
            2'b10: r_slot[0] <= r_slot[1];
            2'b01: begin
                if (r_valid[0]) begin
                    r_slot[1] <= i_data;
                end else begin
                    r_slot[0] <= i_data;
                end
            end
            default: r_slot[0] <= r_slot[0];
        endcase
    end

endmodule

@@ hdl/rle8_bitmap_decoder.sv @@
// 8-bit run-length bitmap decoder, top level. Depends on rle8_pkg, rle8_if,
// rle8_parser and rle8_out_buf.
// Runs are registered in the result buffer and leave it in order on o_run.
// Throughput: one stream byte per cycle, limited only by the two-entry result
// buffer; input stalls when both entries hold untaken runs.
// Reset: width 1, height 1, bottom-up, position row 0 column 0, buffer empty.
module rle8_bitmap_decoder #(
    parameter int unsigned MAX_DIM = rle8_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rle8_cfg_if.sink    i_cfg,
    rle8_byte_if.sink   i_stream,
    rle8_run_if.source  o_run
);
    import rle8_pkg::*;

    t_cfg_wr cfg_wr;
    t_run    res, head;
    logic    res_valid;
    logic    space;
    logic    accept;

    assign i_cfg.ready     = 1'b1;
    assign cfg_wr.valid    = i_cfg.valid;
    assign cfg_wr.index    = i_cfg.index;
    assign cfg_wr.data     = i_cfg.data;

    assign i_stream.ready  = space;
    assign accept          = i_stream.valid && space;

    rle8_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_accept    (accept),
        .i_byte      (i_stream.stream_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rle8_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_run.valid),
        .o_data  (head),
        .i_ready (o_run.ready)
    );

    assign o_run.row_index     = head.row_index;
    assign o_run.column_start  = head.column_start;
    assign o_run.run_length    = head.run_length;
    assign o_run.pixel_value   = head.pixel_value;
    assign o_run.out_of_bounds = head.out_of_bounds;
    assign o_run.bitmap_done   = head.bitmap_done;

endmodule

@@ tb/sv/rle8_bitmap_decoder_test.sv @@
// Self-checking testbench for rle8_bitmap_decoder: drives compressed byte streams,
// predicts every pixel run and end-of-bitmap mark, and checks each run transaction.
// Depends on rle8_pkg and the channel interfaces in rle8_if.
module rle8_bitmap_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rle8_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ROW_HI = 8191;
    localparam int ROW_LO = -8192;
    localparam logic [BYTE_W-1:0] ESCAPE_MARK = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BEAT, RX_HOLD} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rle8_cfg_if  cfg_ch ();
    rle8_byte_if byte_ch ();
    rle8_run_if  run_ch ();

    rle8_bitmap_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_stream(byte_ch),
        .o_run   (run_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state as the predictor sees it
    logic [DIM_W-1:0]        cfg_width;
    logic [DIM_W-1:0]        cfg_height;
    logic                    cfg_bottom_up;
    t_phase                  dec_phase;
    logic [BYTE_W-1:0]       held_count;
    logic [BYTE_W-1:0]       lit_left;
    logic                    pad_due;
    logic [BYTE_W-1:0]       dx_held;
    logic [COL_W-1:0]        col_pos;
    logic signed [ROW_W-1:0] row_pos;

    t_run runs_due[$];
    t_run run_want;
    int   errors = 0;
    int   sent_count = 0;
    int   burst_left = 0;
    int   cycle_count = 0;

    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return int'(MAX_DIM_DEF);
        return int'(v);
    endfunction

    function automatic void rearm_decoder();
        dec_phase  = PH_FIRST;
        held_count = '0;
        lit_left   = '0;
        pad_due    = 1'b0;
        dx_held    = '0;
        col_pos    = '0;
        row_pos    = cfg_bottom_up ? ROW_W'(eff_dim(cfg_height) - 1) : '0;
    endfunction

    function automatic void add_column(int n);
        int c;
        c = int'(col_pos) + n;
        col_pos = (c > int'(DIM_SAT)) ? COL_W'(DIM_SAT) : COL_W'(c);
    endfunction

    function automatic void step_rows(int n);
        int r;
        r = cfg_bottom_up ? int'(row_pos) - n : int'(row_pos) + n;
        if (r > ROW_HI) r = ROW_HI;
        if (r < ROW_LO) r = ROW_LO;
        row_pos = ROW_W'(r);
    endfunction

    // Clamp the row into the image, flag runs that do not fit, then advance the column
    function automatic t_run place_run(int len, logic [BYTE_W-1:0] value);
        int   h;
        int   w;
        int   r;
        logic oob;
        t_run res;
        h   = eff_dim(cfg_height);
        w   = eff_dim(cfg_width);
        r   = int'(row_pos);
        oob = 1'b0;
        if (r < 0) begin
            r   = 0;
            oob = 1'b1;
        end
        if (r >= h) begin
            r   = h - 1;
            oob = 1'b1;
        end
        if (int'(col_pos) + len > w) oob = 1'b1;
        if (r > 4095) r = 4095;
        res.row_index     = OUT_W'(r);
        res.column_start  = (col_pos > 4095) ? 12'd4095 : OUT_W'(col_pos);
        res.run_length    = BYTE_W'(len);
        res.pixel_value   = value;
        res.out_of_bounds = oob;
        res.bitmap_done   = 1'b0;
        add_column(len);
        return res;
    endfunction

    function automatic void decode_byte(logic [BYTE_W-1:0] b);
        t_run mark;
        mark = '0;
        mark.bitmap_done = 1'b1;
        case (dec_phase)
            PH_FIRST: begin
                held_count = b;
                dec_phase  = (b != 0) ? PH_VALUE : PH_ESCAPE;
            end
            PH_VALUE: begin
                dec_phase = PH_FIRST;
                runs_due.push_back(place_run(int'(held_count), b));
            end
            PH_ESCAPE: begin
                if (b == ESC_END_LINE) begin
                    col_pos = '0;
                    step_rows(1);
                    dec_phase = PH_FIRST;
                end else if (b == ESC_END_BITMAP) begin
                    rearm_decoder();
                    runs_due.push_back(mark);
                end else if (b == ESC_DELTA) begin
                    dec_phase = PH_DX;
                end else begin
                    held_count = b;
                    lit_left   = b;
                    pad_due    = b[0];
                    dec_phase  = PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                if (lit_left > 0) lit_left = lit_left - 1'b1;
                if (lit_left == 0) dec_phase = pad_due ? PH_PAD : PH_FIRST;
                runs_due.push_back(place_run(1, b));
            end
            PH_PAD: begin
                pad_due   = 1'b0;
                dec_phase = PH_FIRST;
            end
            PH_DX: begin
                dx_held   = b;
                dec_phase = PH_DY;
            end
            PH_DY: begin
                add_column(int'(dx_held));
                step_rows(int'(b));
                dec_phase = PH_FIRST;
            end
            default: dec_phase = PH_FIRST;
        endcase
    endfunction

    function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [DIM_W-1:0] value);
        logic known;
        known = 1'b1;
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width = value;
            CFG_IMAGE_HEIGHT: cfg_height = value;
            CFG_BOTTOM_UP:    cfg_bottom_up = value[0];
            default:          known = 1'b0;
        endcase
        if (known) rearm_decoder();
    endfunction

    // Track every accepted transaction on the input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width     = 13'd1;
            cfg_height    = 13'd1;
            cfg_bottom_up = 1'b1;
            rearm_decoder();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
            if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.stream_byte);
        end
    end

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && run_ch.valid && run_ch.ready) begin
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run: expected none, got row %0d col %0d len %0d done %0d",
                         $time, run_ch.row_index, run_ch.column_start, run_ch.run_length,
                         run_ch.bitmap_done);
                errors++;
            end else begin
                run_want = runs_due.pop_front();
                check_field("row_index", run_want.row_index, run_ch.row_index);
                check_field("column_start", run_want.column_start, run_ch.column_start);
                check_field("run_length", run_want.run_length, run_ch.run_length);
                check_field("pixel_value", run_want.pixel_value, run_ch.pixel_value);
                check_field("out_of_bounds", run_want.out_of_bounds, run_ch.out_of_bounds);
                check_field("bitmap_done", run_want.bitmap_done, run_ch.bitmap_done);
            end
        end
    end

    // Receiver back-pressure: switch between stall patterns every so often
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 4));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   run_ch.ready <= 1'b1;
            RX_MOSTLY: run_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: run_ch.ready <= ($urandom_range(0, 3) == 0);
            RX_BEAT:   run_ch.ready <= ((rx_tick % 5) >= 3);
            default:   run_ch.ready <= ((rx_tick % 24) >= 18);
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (burst_left == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.stream_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Drain all outstanding runs, then hold off for the pipeline to empty
    task automatic settle();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (runs_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic setup_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic bu);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_BOTTOM_UP, DIM_W'(bu));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic put_run(input int count, input logic [BYTE_W-1:0] value);
        send_byte(BYTE_W'(count));
        send_byte(value);
    endtask

    task automatic put_literals(input int n);
        send_byte(ESCAPE_MARK);
        send_byte(BYTE_W'(n));
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
        if (n % 2 == 1) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic put_end_line();
        send_byte(ESCAPE_MARK);
        send_byte(ESC_END_LINE);
    endtask

    task automatic put_delta(input int dx, input int dy);
        send_byte(ESCAPE_MARK);
        send_byte(ESC_DELTA);
        send_byte(BYTE_W'(dx));
        send_byte(BYTE_W'(dy));
    endtask

    task automatic put_end_bitmap();
        send_byte(ESCAPE_MARK);
        send_byte(ESC_END_BITMAP);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'(MAX_DIM_DEF);
            2:       return DIM_W'(DIM_SAT);
            3:       return DIM_W'($urandom_range(MAX_DIM_DEF + 1, DIM_SAT));
            default: return DIM_W'($urandom_range(1, 48));
        endcase
    endfunction

    task automatic test_directed_streams();
        setup_image(13'd16, 13'd4, 1'b1);
        put_run(5, 8'hAA);
        put_run(255, 8'h00);
        put_end_line();
        put_literals(3);
        put_delta(255, 255);
        put_run(1, 8'hFF);
        put_end_bitmap();
        put_run(2, 8'h5A);
    endtask

    task automatic test_register_limits();
        // zero dimensions act as one
        setup_image(13'd0, 13'd0, 1'b0);
        put_run(1, 8'h01);
        put_run(2, 8'h02);
        put_end_line();
        put_run(1, 8'h03);
        // oversized dimensions act as the maximum
        setup_image(13'd8191, 13'd8191, 1'b1);
        put_run(255, 8'h10);
        put_end_line();
        put_run(3, 8'h11);
        setup_image(13'd4096, 13'd4096, 1'b0);
        put_delta(255, 255);
        put_run(7, 8'h20);
        setup_image(13'd4097, 13'd1, 1'b1);
        put_run(4, 8'h30);
        put_end_line();
        put_run(4, 8'h31);
        // an unknown index leaves the position alone
        setup_image(13'd16, 13'd8, 1'b0);
        put_end_line();
        put_delta(3, 2);
        settle();
        write_reg(CFG_UNUSED, '1);
        cfg_ch.valid <= 1'b0;
        put_run(4, 8'h3C);
        // a write part-way through a pair drops the half-parsed pair
        send_byte(8'd7);
        settle();
        write_reg(CFG_BOTTOM_UP, 13'd1);
        cfg_ch.valid <= 1'b0;
        put_run(2, 8'h81);
        put_end_bitmap();
    endtask

    task automatic test_position_saturation();
        setup_image(13'd8191, 13'd16, 1'b0);
        repeat (34) put_run(255, BYTE_W'($urandom_range(0, 255)));
        put_end_line();
        repeat (33) put_delta(0, 255);
        put_run(1, 8'h44);
        put_end_bitmap();
        setup_image(13'd32, 13'd16, 1'b1);
        repeat (33) put_delta(0, 255);
        put_run(1, 8'h55);
        put_end_bitmap();
    endtask

    task automatic test_random_bitmaps();
        int start;
        int pick;
        repeat (8) begin
            setup_image(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                settle();
                write_reg(CFG_UNUSED, DIM_W'($urandom_range(0, 8191)));
                cfg_ch.valid <= 1'b0;
            end
            start = sent_count;
            while (sent_count - start < 30) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    put_run(($urandom_range(0, 4) == 0) ? $urandom_range(1, 255)
                                                        : $urandom_range(1, 8),
                            BYTE_W'($urandom_range(0, 255)));
                end else if (pick < 58) begin
                    put_literals(($urandom_range(0, 19) == 0) ? $urandom_range(3, 255)
                                                              : $urandom_range(3, 12));
                end else if (pick < 73) begin
                    put_end_line();
                end else if (pick < 84) begin
                    if ($urandom_range(0, 4) == 0)
                        put_delta($urandom_range(0, 255), $urandom_range(0, 255));
                    else
                        put_delta($urandom_range(0, 8), $urandom_range(0, 3));
                end else if (pick < 90) begin
                    put_end_bitmap();
                end else begin
                    // noise: stray bytes that break sequence alignment
                    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        run_ch.ready        = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.stream_byte = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_streams();
        test_register_limits();
        test_position_saturation();
        test_random_bitmaps();

        settle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/rle8_pkg.sv
hdl/rle8_if.sv
hdl/rle8_parser.sv
hdl/rle8_out_buf.sv
hdl/rle8_bitmap_decoder.sv
tb/sv/rle8_bitmap_decoder_test.sv
